/* rtl/sptfl_pkg.sv */
// Shared types and codes for the sorted pair table floor lookup core.
// No dependencies; used by sptfl_cell and sorted_pair_table_floor_lookup_core.
package sptfl_pkg;

   // Request mode codes
   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_LOOKUP = 1'b1;

   // Control handed from the top level to one cell
   typedef struct packed {
      logic insert;         // write this cycle (insert accepted, table not full)
      logic first;          // cell sits at the head of the chain
      logic prev_occupied;  // left neighbor holds a pair
      logic prev_lt;        // left neighbor key is below the new key
   } cell_ctrl_type;

   // Compare flags returned by one cell
   typedef struct packed {
      logic lt_new;    // occupied and key below the new key
      logic le_query;  // occupied and key at or below the query
   } cell_flags_type;

endpackage

/* rtl/sptfl_cell.sv */
// One storage cell of the sorted chain: holds a single (x, y) pair.
// Depends on sptfl_pkg for the control and flag structs.
module sptfl_cell #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                           clock,
   input  sptfl_pkg::cell_ctrl_type       ctrl,
   input  logic                           occupied,
   input  logic signed [VALUE_WIDTH-1:0]  new_x,
   input  logic signed [VALUE_WIDTH-1:0]  new_y,
   input  logic signed [VALUE_WIDTH-1:0]  query_x,
   input  logic signed [VALUE_WIDTH-1:0]  prev_key,
   input  logic signed [VALUE_WIDTH-1:0]  prev_value,
   output logic signed [VALUE_WIDTH-1:0]  key,
   output logic signed [VALUE_WIDTH-1:0]  value,
   output sptfl_pkg::cell_flags_type      flags
);

   logic signed [VALUE_WIDTH-1:0] key_ff, key_in;
   logic signed [VALUE_WIDTH-1:0] value_ff, value_in;
   logic                          take_prev;
   logic                          take_new;

   // Compare the held key against the broadcast keys
   assign flags.lt_new   = occupied && (key_ff < new_x);
   assign flags.le_query = occupied && (key_ff <= query_x);

   // Shift right when the left neighbor holds a pair that is not below the new key;
   // take the new pair at the first slot that is not below it
   assign take_prev = ctrl.insert && !ctrl.first && ctrl.prev_occupied && !ctrl.prev_lt;
   assign take_new  = ctrl.insert && !flags.lt_new && (ctrl.first || ctrl.prev_lt);

   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      if (take_prev) begin
         key_in   = prev_key;
         value_in = prev_value;
      end else if (take_new) begin
         key_in   = new_x;
         value_in = new_y;
      end
   end

   // Hold or load the pair
   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   assign key   = key_ff;
   assign value = value_ff;

endmodule

/* rtl/sorted_pair_table_floor_lookup_core.sv */
// Sorted pair table with floor lookup: top level.
// Depends on sptfl_pkg and sptfl_cell.
//
// Holds up to TABLE_DEPTH signed (x, y) pairs in a chain of cells, sorted by x
// ascending; an insert goes before the first held x that is not below the new
// x, a lookup returns the floor entry for query_x (index 0 below the smallest
// x, the last index at or above the largest). Every transfer in yields one
// transfer out. All cells compare against the broadcast key in parallel and
// shift toward their right neighbor in the same edge, and the result is
// registered. A new request is taken whenever the result register is empty
// or being emptied in that cycle. Inserts into a full table are dropped with
// full_drop; lookups on an empty table raise empty_lookup with index and
// pair zero. The running x and y bounds start at the most positive (minimum)
// and most negative (maximum) values.
module sorted_pair_table_floor_lookup_core #(
   parameter int TABLE_DEPTH = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_mode,
   input  logic signed [VALUE_WIDTH-1:0]          req_new_x,
   input  logic signed [VALUE_WIDTH-1:0]          req_new_y,
   input  logic signed [VALUE_WIDTH-1:0]          req_query_x,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [$clog2(TABLE_DEPTH)-1:0]         rsp_found_index,
   output logic signed [VALUE_WIDTH-1:0]          rsp_found_x,
   output logic signed [VALUE_WIDTH-1:0]          rsp_found_y,
   output logic [$clog2(TABLE_DEPTH+1)-1:0]       rsp_entry_count,
   output logic signed [VALUE_WIDTH-1:0]          rsp_x_low,
   output logic signed [VALUE_WIDTH-1:0]          rsp_x_high,
   output logic signed [VALUE_WIDTH-1:0]          rsp_y_low,
   output logic signed [VALUE_WIDTH-1:0]          rsp_y_high,
   output logic                                   rsp_full_drop,
   output logic                                   rsp_empty_lookup
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic signed [VALUE_WIDTH-1:0] MOST_POS = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
   localparam logic signed [VALUE_WIDTH-1:0] MOST_NEG = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

   logic                          accept;
   logic                          do_insert;
   logic                          is_full;
   logic                          is_empty;

   logic [CNT_W-1:0]              count_ff, count_in;
   logic signed [VALUE_WIDTH-1:0] min_x_ff, min_x_in;
   logic signed [VALUE_WIDTH-1:0] max_x_ff, max_x_in;
   logic signed [VALUE_WIDTH-1:0] min_y_ff, min_y_in;
   logic signed [VALUE_WIDTH-1:0] max_y_ff, max_y_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]              found_index_ff, found_index_in;
   logic signed [VALUE_WIDTH-1:0] found_x_ff, found_x_in;
   logic signed [VALUE_WIDTH-1:0] found_y_ff, found_y_in;
   logic                          full_drop_ff, full_drop_in;
   logic                          empty_lookup_ff, empty_lookup_in;

   logic signed [VALUE_WIDTH-1:0] cell_key   [TABLE_DEPTH];
   logic signed [VALUE_WIDTH-1:0] cell_value [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0]        occupied;
   logic [TABLE_DEPTH-1:0]        floor_sel;
   sptfl_pkg::cell_flags_type     cell_flags [TABLE_DEPTH];
   sptfl_pkg::cell_ctrl_type      cell_ctrl  [TABLE_DEPTH];

   logic [IDX_W-1:0]              sel_index;
   logic signed [VALUE_WIDTH-1:0] sel_x;
   logic signed [VALUE_WIDTH-1:0] sel_y;

   // Handshake: take a request unless a result waits stalled
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign is_full   = (count_ff >= CNT_W'(TABLE_DEPTH));
   assign is_empty  = (count_ff == '0);
   assign do_insert = accept && (req_mode == sptfl_pkg::MODE_INSERT) && !is_full;

   // Chain of cells
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      assign occupied[i] = (CNT_W'(i) < count_ff);

      if (i == 0) begin : g_head
         assign cell_ctrl[i].first         = 1'b1;
         assign cell_ctrl[i].prev_occupied = 1'b0;
         assign cell_ctrl[i].prev_lt       = 1'b0;
      end else begin : g_body
         assign cell_ctrl[i].first         = 1'b0;
         assign cell_ctrl[i].prev_occupied = occupied[i-1];
         assign cell_ctrl[i].prev_lt       = cell_flags[i-1].lt_new;
      end
      assign cell_ctrl[i].insert = do_insert;

      sptfl_cell #(
         .VALUE_WIDTH (VALUE_WIDTH)
      ) u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl[i]),
         .occupied   (occupied[i]),
         .new_x      (req_new_x),
         .new_y      (req_new_y),
         .query_x    (req_query_x),
         .prev_key   ((i == 0) ? req_new_x : cell_key[(i == 0) ? 0 : i-1]),
         .prev_value ((i == 0) ? req_new_y : cell_value[(i == 0) ? 0 : i-1]),
         .key        (cell_key[i]),
         .value      (cell_value[i]),
         .flags      (cell_flags[i])
      );

      // Floor cell: occupied, at or below the query (or the head), and the
      // next cell is not at or below the query
      if (i == TABLE_DEPTH - 1) begin : g_sel_tail
         assign floor_sel[i] = occupied[i] && ((i == 0) || cell_flags[i].le_query);
      end else begin : g_sel_body
         assign floor_sel[i] = occupied[i] && ((i == 0) || cell_flags[i].le_query)
                               && !cell_flags[i+1].le_query;
      end
   end

   // Gather the one selected cell
   always_comb begin
      sel_index = '0;
      sel_x     = '0;
      sel_y     = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (floor_sel[i]) begin
            sel_index = sel_index | IDX_W'(i);
            sel_x     = sel_x | cell_key[i];
            sel_y     = sel_y | cell_value[i];
         end
      end
   end

   // Next count, bounds and result
   always_comb begin
      count_in        = count_ff;
      min_x_in        = min_x_ff;
      max_x_in        = max_x_ff;
      min_y_in        = min_y_ff;
      max_y_in        = max_y_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      found_index_in  = found_index_ff;
      found_x_in      = found_x_ff;
      found_y_in      = found_y_ff;
      full_drop_in    = full_drop_ff;
      empty_lookup_in = empty_lookup_ff;
      if (do_insert) begin
         count_in = count_ff + CNT_W'(1);
         if (req_new_x < min_x_ff) min_x_in = req_new_x;
         if (req_new_x > max_x_ff) max_x_in = req_new_x;
         if (req_new_y < min_y_ff) min_y_in = req_new_y;
         if (req_new_y > max_y_ff) max_y_in = req_new_y;
      end
      if (accept) begin
         rsp_valid_in    = 1'b1;
         found_index_in  = '0;
         found_x_in      = '0;
         found_y_in      = '0;
         full_drop_in    = 1'b0;
         empty_lookup_in = 1'b0;
         if (req_mode == sptfl_pkg::MODE_INSERT) begin
            full_drop_in = is_full;
         end else if (is_empty) begin
            empty_lookup_in = 1'b1;
         end else begin
            found_index_in = sel_index;
            found_x_in     = sel_x;
            found_y_in     = sel_y;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         min_x_ff     <= MOST_POS;
         max_x_ff     <= MOST_NEG;
         min_y_ff     <= MOST_POS;
         max_y_ff     <= MOST_NEG;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         min_x_ff     <= min_x_in;
         max_x_ff     <= max_x_in;
         min_y_ff     <= min_y_in;
         max_y_ff     <= max_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      found_index_ff  <= found_index_in;
      found_x_ff      <= found_x_in;
      found_y_ff      <= found_y_in;
      full_drop_ff    <= full_drop_in;
      empty_lookup_ff <= empty_lookup_in;
   end

   // Count and bounds change only on a transfer in, which also loads the result
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found_index  = found_index_ff;
   assign rsp_found_x      = found_x_ff;
   assign rsp_found_y      = found_y_ff;
   assign rsp_entry_count  = count_ff;
   assign rsp_x_low        = min_x_ff;
   assign rsp_x_high       = max_x_ff;
   assign rsp_y_low        = min_y_ff;
   assign rsp_y_high       = max_y_ff;
   assign rsp_full_drop    = full_drop_ff;
   assign rsp_empty_lookup = empty_lookup_ff;

endmodule
